### rtl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types, codes and helpers for the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam logic [7:0] ALLOC_MASK = 8'b0000_0001;
  localparam logic [7:0] SIZE_MASK  = 8'b1111_1110;

  typedef enum logic [2:0] {
    CMD_MALLOC  = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_REALLOC = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_BADADDR = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RDWAIT,
    S_BF_CHK,
    S_BF_END,
    S_BF_SPLIT,
    S_BF_DONE,
    S_CP_RD,
    S_CP_WR,
    S_RL_START,
    S_RL_HDR,
    S_RL_NXT,
    S_RS_HDR,
    S_RS_SHR2,
    S_RS_EXP,
    S_RS_EXPCHK,
    S_RS_DEC,
    S_RS_GROW2
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  function automatic logic [7:0] hdr_pack(logic [7:0] size, logic alloc);
    logic [7:0] v;
    v = ({size[6:0], 1'b0} & SIZE_MASK) | (alloc ? ALLOC_MASK : 8'h00);
    return v;
  endfunction

endpackage

### rtl/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit byte heap allocator over one store of one-byte-header blocks.
// ----------------------------------------------------------------------------
// One transaction at a time. Every step of a command makes at most one store
// read and one store write, and read data comes back through a register, so
// the store port sets the time. A byte write or read makes one store access,
// malloc reads each header of the heap in turn, free merges each free block
// that follows, and a realloc that moves adds the malloc walk and one read
// and one write per copied payload byte. The result stays in an output
// register until taken; a new transaction is accepted when that register is
// empty or is being taken in the same cycle.
module best_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 127
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [6:0] address_i,
  input  logic [6:0] size_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] alloc_ptr_o,
  output logic [1:0] status_o,
  output logic [7:0] read_data_o
);
  import bfha_pkg::*;

  localparam logic [7:0] HB = 8'(HEAP_BYTES);

  state_e     state_q, state_d;
  cmd_e       cmd_q, cmd_d;
  logic [6:0] addr_q, addr_d;
  logic [6:0] size_q, size_d;
  logic [7:0] wdata_q, wdata_d;
  logic [7:0] cur_q, cur_d;
  logic [7:0] best_q, best_d;
  logic [7:0] bsize_q, bsize_d;
  logic       found_q, found_d;
  logic [7:0] hsz_q, hsz_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] cnt_q, cnt_d;
  logic       asc_q, asc_d;
  logic [7:0] naddr_q, naddr_d;
  logic [6:0] resp_q, resp_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] pa_q, pa_d;
  status_e    st_q, st_d;
  logic [7:0] rd_q, rd_d;

  mem_req_t   req;
  logic [7:0] rdata;
  logic [7:0] hs;
  logic       ha;
  logic [7:0] want;
  logic [7:0] addr8;

  bfha_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rdata_o(rdata)
  );

  function automatic logic hdr_bad(logic [7:0] idx, logic [7:0] s);
    return (s == 8'd0) || ((idx + s) > HB);
  endfunction

  assign hs    = {1'b0, rdata[7:1]};
  assign ha    = rdata[0];
  assign want  = {1'b0, size_q} + 8'd1;
  assign addr8 = {1'b0, addr_q};

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign alloc_ptr_o = pa_q;
  assign status_o    = st_q;
  assign read_data_o = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    addr_q  <= addr_d;
    size_q  <= size_d;
    wdata_q <= wdata_d;
    cur_q   <= cur_d;
    best_q  <= best_d;
    bsize_q <= bsize_d;
    found_q <= found_d;
    hsz_q   <= hsz_d;
    acc_q   <= acc_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    asc_q   <= asc_d;
    naddr_q <= naddr_d;
    resp_q  <= resp_d;
    pa_q    <= pa_d;
    st_q    <= st_d;
    rd_q    <= rd_d;
  end

  always_comb begin
    logic       fin;
    status_e    fst;
    logic [6:0] fres;
    logic [7:0] frd;
    logic [7:0] nx;
    logic [7:0] t;
    logic [7:0] n;

    fin  = 1'b0;
    fst  = ST_OK;
    fres = '0;
    frd  = '0;
    nx   = '0;
    t    = '0;
    n    = hsz_q - 8'd1;

    state_d     = state_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    size_d      = size_q;
    wdata_d     = wdata_q;
    cur_d       = cur_q;
    best_d      = best_q;
    bsize_d     = bsize_q;
    found_d     = found_q;
    hsz_d       = hsz_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    asc_d       = asc_q;
    naddr_d     = naddr_q;
    resp_d      = resp_q;
    pa_d        = pa_q;
    st_d        = st_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    req         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_d   = cmd_e'(command_i);
          addr_d  = address_i;
          size_d  = size_i;
          wdata_d = write_data_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (cmd_q)
          CMD_MALLOC: begin
            cur_d       = '0;
            bsize_d     = HB + 8'd1;
            found_d     = 1'b0;
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
            state_d     = S_BF_CHK;
          end
          CMD_FREE, CMD_REALLOC: begin
            if (addr_q == '0 || addr8 > HB) begin
              fin = 1'b1;
              fst = ST_BADADDR;
            end else begin
              idx_d  = addr8 - 8'd1;
              resp_d = '0;
              if (cmd_q == CMD_FREE) begin
                state_d = S_RL_START;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = addr_q - 7'd1;
                state_d     = S_RS_HDR;
              end
            end
          end
          CMD_WRITE: begin
            fin = 1'b1;
            if (addr8 < HB) begin
              req.wr_en   = 1'b1;
              req.wr_addr = addr_q;
              req.wr_data = wdata_q;
            end else begin
              fst = ST_BADADDR;
            end
          end
          CMD_READ: begin
            if (addr8 < HB) begin
              req.rd_en   = 1'b1;
              req.rd_addr = addr_q;
              state_d     = S_RDWAIT;
            end else begin
              fin = 1'b1;
              fst = ST_BADADDR;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_RDWAIT: begin
        fin = 1'b1;
        frd = rdata;
      end
      S_BF_CHK: begin
        if (hdr_bad(cur_q, hs)) begin
          fin = 1'b1;
          fst = ST_CORRUPT;
        end else begin
          if (!ha && hs >= want && hs < bsize_q) begin
            best_d  = cur_q;
            bsize_d = hs;
            found_d = 1'b1;
          end
          nx    = cur_q + hs;
          cur_d = nx;
          if (nx < HB) begin
            req.rd_en   = 1'b1;
            req.rd_addr = nx[6:0];
          end else begin
            state_d = S_BF_END;
          end
        end
      end
      S_BF_END: begin
        if (!found_q) begin
          fin = 1'b1;
          fst = ST_NOSPACE;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = best_q[6:0];
          if (bsize_q - want >= 8'd2) begin
            req.wr_data = hdr_pack(want, 1'b1);
            state_d     = S_BF_SPLIT;
          end else begin
            req.wr_data = hdr_pack(bsize_q, 1'b1);
            state_d     = S_BF_DONE;
          end
        end
      end
      S_BF_SPLIT: begin
        t           = best_q + want;
        req.wr_en   = 1'b1;
        req.wr_addr = t[6:0];
        req.wr_data = hdr_pack(bsize_q - want, 1'b0);
        state_d     = S_BF_DONE;
      end
      S_BF_DONE: begin
        t = best_q + 8'd1;
        if (cmd_q == CMD_MALLOC) begin
          fin  = 1'b1;
          fres = t[6:0];
        end else begin
          naddr_d = t;
          idx_d   = addr8 - 8'd1;
          resp_d  = t[6:0];
          if ((t + n) <= HB && (addr8 + n) <= HB && n != 8'd0) begin
            asc_d   = t < addr8;
            cnt_d   = (t < addr8) ? 8'd0 : n - 8'd1;
            state_d = S_CP_RD;
          end else begin
            state_d = S_RL_START;
          end
        end
      end
      S_CP_RD: begin
        t           = addr8 + cnt_q;
        req.rd_en   = 1'b1;
        req.rd_addr = t[6:0];
        state_d     = S_CP_WR;
      end
      S_CP_WR: begin
        t           = naddr_q + cnt_q;
        req.wr_en   = 1'b1;
        req.wr_addr = t[6:0];
        req.wr_data = rdata;
        if (asc_q ? (cnt_q == n - 8'd1) : (cnt_q == 8'd0)) begin
          state_d = S_RL_START;
        end else begin
          cnt_d   = asc_q ? cnt_q + 8'd1 : cnt_q - 8'd1;
          state_d = S_CP_RD;
        end
      end
      S_RL_START: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx_q[6:0];
        state_d     = S_RL_HDR;
      end
      S_RL_HDR: begin
        if (hdr_bad(idx_q, hs)) begin
          fin = 1'b1;
          fst = ST_CORRUPT;
        end else begin
          req.wr_en   = 1'b1;
          req.wr_addr = idx_q[6:0];
          req.wr_data = hdr_pack(hs, 1'b0);
          acc_d       = hs;
          nx          = idx_q + hs;
          cur_d       = nx;
          if (nx < HB) begin
            req.rd_en   = 1'b1;
            req.rd_addr = nx[6:0];
            state_d     = S_RL_NXT;
          end else begin
            fin  = 1'b1;
            fres = resp_q;
          end
        end
      end
      S_RL_NXT: begin
        if (ha) begin
          fin  = 1'b1;
          fres = resp_q;
        end else if (hdr_bad(cur_q, hs)) begin
          fin = 1'b1;
          fst = ST_CORRUPT;
        end else begin
          t           = acc_q + hs;
          acc_d       = t;
          req.wr_en   = 1'b1;
          req.wr_addr = idx_q[6:0];
          req.wr_data = hdr_pack(t, 1'b0);
          nx          = cur_q + hs;
          cur_d       = nx;
          if (nx < HB) begin
            req.rd_en   = 1'b1;
            req.rd_addr = nx[6:0];
          end else begin
            fin  = 1'b1;
            fres = resp_q;
          end
        end
      end
      S_RS_HDR: begin
        if (hdr_bad(idx_q, hs)) begin
          fin = 1'b1;
          fst = ST_CORRUPT;
        end else begin
          hsz_d = hs;
          if (want + 8'd1 < hs) begin
            req.wr_en   = 1'b1;
            req.wr_addr = idx_q[6:0];
            req.wr_data = hdr_pack(want, 1'b1);
            state_d     = S_RS_SHR2;
          end else if (want <= hs) begin
            fin  = 1'b1;
            fres = addr_q;
          end else begin
            acc_d   = '0;
            cur_d   = idx_q + hs;
            state_d = S_RS_EXP;
          end
        end
      end
      S_RS_SHR2: begin
        t           = idx_q + want;
        req.wr_en   = 1'b1;
        req.wr_addr = t[6:0];
        req.wr_data = hdr_pack(hsz_q - want, 1'b1);
        idx_d       = t;
        resp_d      = addr_q;
        state_d     = S_RL_START;
      end
      S_RS_EXP: begin
        if (cur_q < HB && want > acc_q + hsz_q) begin
          req.rd_en   = 1'b1;
          req.rd_addr = cur_q[6:0];
          state_d     = S_RS_EXPCHK;
        end else begin
          state_d = S_RS_DEC;
        end
      end
      S_RS_EXPCHK: begin
        if (ha) begin
          state_d = S_RS_DEC;
        end else if (hdr_bad(cur_q, hs)) begin
          fin = 1'b1;
          fst = ST_CORRUPT;
        end else begin
          acc_d   = acc_q + hs;
          cur_d   = cur_q + hs;
          state_d = S_RS_EXP;
        end
      end
      S_RS_DEC: begin
        t = hsz_q + acc_q;
        if (want == t || want + 8'd1 == t) begin
          req.wr_en   = 1'b1;
          req.wr_addr = idx_q[6:0];
          req.wr_data = hdr_pack(t, 1'b1);
          fin         = 1'b1;
          fres        = addr_q;
        end else if (want + 8'd1 < t) begin
          nx          = idx_q + want;
          req.wr_en   = 1'b1;
          req.wr_addr = nx[6:0];
          req.wr_data = hdr_pack(t - want, 1'b0);
          state_d     = S_RS_GROW2;
        end else begin
          cur_d       = '0;
          bsize_d     = HB + 8'd1;
          found_d     = 1'b0;
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
          state_d     = S_BF_CHK;
        end
      end
      S_RS_GROW2: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_q[6:0];
        req.wr_data = hdr_pack(want, 1'b1);
        fin         = 1'b1;
        fres        = addr_q;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      out_valid_d = 1'b1;
      st_d        = fst;
      pa_d        = (fst == ST_OK) ? fres : 7'd0;
      rd_d        = frd;
      state_d     = S_IDLE;
    end
  end

  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result pending while a transaction is in progress");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && st_q != ST_OK) |-> (pa_q == 7'd0))
    else $error("failed transaction returned a block pointer");

  a_rd_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rd_q != 8'd0) |-> (cmd_q == CMD_READ))
    else $error("read data returned by a non-read command");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr_en |-> ({1'b0, req.wr_addr} < HB))
    else $error("store write outside the heap");

endmodule

### rtl/bfha_mem.sv
// ----------------------------------------------------------------------------
// bfha_mem
// Heap byte store: one write and one registered read per cycle, with
// per-entry valid bits that give the reset image until an entry is written.
// ----------------------------------------------------------------------------
module bfha_mem #(
  parameter int unsigned HEAP_BYTES = 127
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfha_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);
  import bfha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam logic [7:0] INIT0 = 8'(HEAP_BYTES * 2);

  logic [7:0]            mem_q [HEAP_BYTES];
  logic [HEAP_BYTES-1:0] valid_q;
  logic [7:0]            rdata_q;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         wa;

  assign ra = req_i.rd_addr[AW-1:0];
  assign wa = req_i.wr_addr[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wa] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      if (valid_q[ra]) begin
        rdata_q <= mem_q[ra];
      end else begin
        rdata_q <= (ra == '0) ? INIT0 : 8'h00;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### bench/best_fit_heap_allocator_tb.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_tb
// Self-checking bench for the best-fit heap allocator. A behavioral copy of
// the heap predicts the result of each accepted transaction; a monitor checks
// every taken result against the oldest prediction, under varying idle and
// stall pressure on both channels.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfha_pkg::*;

  localparam int HEAP = 127;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] CMD_SPARE = 3'd5;

  typedef struct packed {
    logic [6:0] paddr;
    status_e    status;
    logic [7:0] rdata;
  } heap_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] command_i = '0;
  logic [6:0] address_i = '0;
  logic [6:0] size_i = '0;
  logic [7:0] write_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] alloc_ptr_o;
  logic [1:0] status_o;
  logic [7:0] read_data_o;

  logic [7:0]   heap_mem [0:HEAP-1];
  heap_result_t pending_results[$];
  int           live_ptrs[$];
  int           gap_pct = 0;
  int           stall_pct = 0;
  int           cycles = 0;
  int           mismatches = 0;
  int           sent = 0;
  int           taken = 0;
  int           status_seen[4] = '{0, 0, 0, 0};

  best_fit_heap_allocator dut (.*);

  always #2 clk_i = ~clk_i;

  // ---------------- heap predictor ----------------
  function automatic int hsize(int i);
    return (i < HEAP) ? int'(heap_mem[i][7:1]) : 0;
  endfunction

  function automatic bit halloc(int i);
    return (i < HEAP) ? heap_mem[i][0] : 1'b1;
  endfunction

  function automatic bit hbad(int i);
    int s;
    s = hsize(i);
    return s == 0 || i + s > HEAP;
  endfunction

  function automatic void hwrite(int i, int s, bit a);
    if (i < HEAP) heap_mem[i] = {s[6:0], a};
  endfunction

  function automatic status_e merge_free(int idx);
    int s;
    int nxt;
    if (hbad(idx)) return ST_CORRUPT;
    s = hsize(idx);
    hwrite(idx, s, 1'b0);
    nxt = idx + s;
    while (nxt < HEAP && !halloc(nxt)) begin
      if (hbad(nxt)) return ST_CORRUPT;
      s += hsize(nxt);
      hwrite(idx, s, 1'b0);
      nxt += hsize(nxt);
    end
    return ST_OK;
  endfunction

  function automatic status_e best_fit_take(int payload, output int pa);
    int req;
    int best;
    int best_sz;
    int cur;
    int s;
    bit found;
    req = payload + 1;
    best = 0;
    best_sz = HEAP + 1;
    cur = 0;
    found = 0;
    pa = 0;
    while (cur < HEAP) begin
      if (hbad(cur)) return ST_CORRUPT;
      s = hsize(cur);
      if (!halloc(cur) && s >= req && s < best_sz) begin
        best = cur;
        best_sz = s;
        found = 1;
      end
      cur += s;
    end
    if (!found) return ST_NOSPACE;
    if (best_sz - req >= 2) begin
      hwrite(best, req, 1'b1);
      hwrite(best + req, best_sz - req, 1'b0);
    end else begin
      hwrite(best, best_sz, 1'b1);
    end
    pa = best + 1;
    return ST_OK;
  endfunction

  function automatic status_e resize_block(int pa, int payload, output int ra);
    int h;
    int want;
    int cur;
    int adj;
    int nxt;
    int total;
    int na;
    status_e st;
    logic [7:0] tmp [0:HEAP-1];
    h = pa - 1;
    want = payload + 1;
    ra = 0;
    if (hbad(h)) return ST_CORRUPT;
    cur = hsize(h);
    if (want + 1 < cur) begin
      hwrite(h, want, 1'b1);
      hwrite(h + want, cur - want, 1'b1);
      st = merge_free(h + want);
      if (st == ST_OK) ra = pa;
      return st;
    end
    if (want <= cur) begin
      ra = pa;
      return ST_OK;
    end
    adj = 0;
    nxt = h + cur;
    while (nxt < HEAP && !halloc(nxt) && want > adj + cur) begin
      if (hbad(nxt)) return ST_CORRUPT;
      adj += hsize(nxt);
      nxt += hsize(nxt);
    end
    total = cur + adj;
    if (want == total || want + 1 == total) begin
      hwrite(h, total, 1'b1);
      ra = pa;
      return ST_OK;
    end
    if (want + 1 < total) begin
      hwrite(h + want, total - want, 1'b0);
      hwrite(h, want, 1'b1);
      ra = pa;
      return ST_OK;
    end
    st = best_fit_take(payload, na);
    if (st != ST_OK) return st;
    if (na + cur - 1 <= HEAP && pa + cur - 1 <= HEAP) begin
      tmp = heap_mem;
      for (int k = 0; k < cur - 1; k++) heap_mem[na + k] = tmp[pa + k];
    end
    st = merge_free(h);
    if (st == ST_OK) ra = na;
    return st;
  endfunction

  function automatic void heap_predict(logic [2:0] cmd, int a, int sz, logic [7:0] d);
    heap_result_t r;
    int pa;
    r = '{paddr: '0, status: ST_OK, rdata: '0};
    pa = 0;
    case (cmd)
      CMD_MALLOC: begin
        r.status = best_fit_take(sz, pa);
        if (r.status == ST_OK) live_ptrs.push_back(pa);
      end
      CMD_FREE: begin
        if (a == 0 || a > HEAP) r.status = ST_BADADDR;
        else r.status = merge_free(a - 1);
        if (r.status == ST_OK)
          foreach (live_ptrs[k]) if (live_ptrs[k] == a) begin
            live_ptrs.delete(k);
            break;
          end
      end
      CMD_REALLOC: begin
        if (a == 0 || a > HEAP) r.status = ST_BADADDR;
        else r.status = resize_block(a, sz, pa);
        if (r.status == ST_OK)
          foreach (live_ptrs[k]) if (live_ptrs[k] == a) begin
            live_ptrs[k] = pa;
            break;
          end
      end
      CMD_WRITE: begin
        if (a < HEAP) heap_mem[a] = d;
        else r.status = ST_BADADDR;
      end
      CMD_READ: begin
        if (a < HEAP) r.rdata = heap_mem[a];
        else r.status = ST_BADADDR;
      end
      default: ;
    endcase
    if (r.status != ST_OK) pa = 0;
    r.paddr = pa[6:0];
    pending_results.push_back(r);
  endfunction

  // ---------------- channels ----------------
  task automatic send_item(logic [2:0] cmd, int a, int sz, logic [7:0] d);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    address_i    <= a[6:0];
    size_i       <= sz[6:0];
    write_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    heap_predict(cmd, a, sz, d);
    sent++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", taken, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    heap_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, -1);
      end else begin
        e = pending_results.pop_front();
        if (alloc_ptr_o != e.paddr)
          report_mismatch("alloc_ptr", alloc_ptr_o, e.paddr);
        if (status_o != e.status) report_mismatch("status", status_o, e.status);
        if (read_data_o != e.rdata) report_mismatch("read_data", read_data_o, e.rdata);
        status_seen[e.status]++;
      end
      taken++;
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------- tests ----------------
  task automatic reinit_heap();
    send_item(CMD_WRITE, 0, 0, 8'hFE);
    live_ptrs.delete();
  endtask

  task automatic test_byte_access();
    send_item(CMD_WRITE, 126, 0, 8'hFF);
    send_item(CMD_READ, 126, 0, 8'h00);
    send_item(CMD_WRITE, 127, 0, 8'hA5);
    send_item(CMD_READ, 127, 0, 8'h00);
    send_item(CMD_READ, 0, 0, 8'h00);
  endtask

  task automatic test_malloc_free();
    reinit_heap();
    send_item(CMD_MALLOC, 0, 127, 8'h00);
    send_item(CMD_MALLOC, 0, 126, 8'h00);
    send_item(CMD_FREE, 1, 0, 8'h00);
    send_item(CMD_MALLOC, 0, 0, 8'h00);
    send_item(CMD_MALLOC, 0, 10, 8'h00);
    send_item(CMD_MALLOC, 0, 124, 8'h00);
    send_item(CMD_FREE, 2, 0, 8'h00);
    send_item(CMD_FREE, 1, 0, 8'h00);
    send_item(CMD_FREE, 0, 0, 8'h00);
    send_item(CMD_SPARE, 5, 5, 8'h55);
    send_item(3'd7, 127, 127, 8'hFF);
  endtask

  task automatic test_realloc();
    reinit_heap();
    send_item(CMD_MALLOC, 0, 20, 8'h00);
    send_item(CMD_MALLOC, 0, 5, 8'h00);
    send_item(CMD_WRITE, 1, 0, 8'h3C);
    send_item(CMD_REALLOC, 1, 4, 8'h00);
    send_item(CMD_REALLOC, 1, 18, 8'h00);
    send_item(CMD_REALLOC, 1, 40, 8'h00);
    send_item(CMD_REALLOC, 0, 3, 8'h00);
    send_item(CMD_REALLOC, 23, 100, 8'h00);
  endtask

  task automatic test_faults();
    send_item(CMD_WRITE, 0, 0, 8'h00);
    send_item(CMD_MALLOC, 0, 3, 8'h00);
    send_item(CMD_WRITE, 0, 0, 8'hFF);
    send_item(CMD_FREE, 1, 0, 8'h00);
    send_item(CMD_REALLOC, 127, 1, 8'h00);
    reinit_heap();
  endtask

  task automatic test_random_traffic(int n);
    int r;
    int p;
    int sz;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      sz = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(20);
      p = live_ptrs.size() ? live_ptrs[$urandom_range(live_ptrs.size() - 1)] : 1;
      if (r < 3) reinit_heap();
      else if (r < 30 || live_ptrs.size() == 0)
        send_item(CMD_MALLOC, $urandom_range(127), sz, 8'($urandom_range(255)));
      else if (r < 48)
        send_item(CMD_FREE, p, $urandom_range(127), 8'($urandom_range(255)));
      else if (r < 63) send_item(CMD_REALLOC, p, sz, 8'($urandom_range(255)));
      else if (r < 75)
        send_item(CMD_WRITE, (p + $urandom_range(4)) % HEAP, 0, 8'($urandom_range(255)));
      else if (r < 88) send_item(CMD_READ, (p + $urandom_range(4)) % HEAP, 0, 8'h00);
      else if (r < 92) send_item(CMD_FREE, $urandom_range(127), 0, 8'h00);
      else if (r < 95)
        send_item(CMD_REALLOC, $urandom_range(127), $urandom_range(127), 8'h00);
      else if (r < 98)
        send_item(3'($urandom_range(4)), $urandom_range(127), $urandom_range(127),
                  8'($urandom_range(255)));
      else
        send_item(3'($urandom_range(7, 5)), $urandom_range(127), $urandom_range(127),
                  8'($urandom_range(255)));
    end
  endtask

  initial begin
    for (int k = 0; k < HEAP; k++) heap_mem[k] = 8'h00;
    heap_mem[0] = 8'hFE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_byte_access();
    test_malloc_free();
    test_realloc();
    test_faults();
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 47) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 47) : 0;
      test_random_traffic(270);
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    $display("sent %0d transactions, took %0d results under four idle/stall mixes",
             sent, taken);
    $display("status ok %0d, no space %0d, corrupt %0d, bad address %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
